// File: rtl/vnu_pkg.sv
// Shared types and constants for the vector normalize unit.
package vnu_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/vnu_vec_if.sv
// Input channel: one vector per beat.
interface vnu_vec_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] z_in;

    modport source (output valid, x_in, y_in, z_in, input ready);
    modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

// File: rtl/vnu_unit_if.sv
// Output channel: one normalized vector per beat.
interface vnu_unit_if #(
    parameter int UW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [UW-1:0] x_unit;
    logic signed [UW-1:0] y_unit;
    logic signed [UW-1:0] z_unit;
    logic                 zero_length;

    modport source (output valid, x_unit, y_unit, z_unit, zero_length, input ready);
    modport sink (input valid, x_unit, y_unit, z_unit, zero_length, output ready);
endinterface

// File: rtl/vector3_normalize_unit.sv
// Top level of the three-component vector normalize unit.
// Takes one vector per beat and returns each component divided by the vector length as
// a signed fixed-point value with FRACTION_BITS fraction bits, rounded to nearest with
// ties away from zero; an all-zero vector gives zero components and zero_length high.
// Fully pipelined: one vector per cycle sustained while the output side takes each result.
// The path runs through two front stages (sign split, squaring), one queue slot, one setup
// stage, FRACTION_BITS + 1 stages that each settle one result bit by shift-and-add, and
// the output register. The two-entry queue lets the front end keep accepting while the
// back end is held by the output side.
module vector3_normalize_unit #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    vnu_vec_if.sink    vec,
    vnu_unit_if.source unit
);
    localparam int DW = 3 * (2 * COMPONENT_WIDTH + 1);

    vnu_pkg::queue_status_t qs;
    logic                   push;
    logic                   pop;
    logic [DW-1:0]          push_data;
    logic [DW-1:0]          pop_data;

    vnu_front #(
        .W (COMPONENT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec       (vec),
        .qs        (qs),
        .push      (push),
        .push_data (push_data)
    );

    vnu_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qs        (qs)
    );

    vnu_back #(
        .W (COMPONENT_WIDTH),
        .F (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qs       (qs),
        .pop_data (pop_data),
        .pop      (pop),
        .unit     (unit)
    );
endmodule

// File: rtl/vnu_front.sv
// Front end: accepts vectors, splits sign and magnitude, squares the magnitudes.
module vnu_front #(
    parameter int W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    vnu_vec_if.sink                     vec,
    input  vnu_pkg::queue_status_t      qs,
    output logic                        push,
    output logic [3*(2*W+1)-1:0]        push_data
);
    localparam int SW = 2 * W;

    logic             v1_reg;
    logic             v2_reg;
    logic [W-1:0]     mag_reg [3];
    logic [2:0]       neg1_reg;
    logic [SW-1:0]    sq_reg [3];
    logic [2:0]       neg2_reg;
    logic             en;
    logic signed [W-1:0] comp [3];

    assign en        = !v2_reg || !qs.full;
    assign push      = v2_reg && !qs.full;
    assign vec.ready = en;

    assign comp[0] = vec.x_in;
    assign comp[1] = vec.y_in;
    assign comp[2] = vec.z_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vec.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                neg1_reg[j] <= comp[j][W-1];
                mag_reg[j]  <= comp[j][W-1] ? (~comp[j] + W'(1)) : comp[j];
                sq_reg[j]   <= SW'(mag_reg[j]) * SW'(mag_reg[j]);
            end
            neg2_reg <= neg1_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            push_data[j*(SW+1) +: SW] = sq_reg[j];
            push_data[j*(SW+1) + SW]  = neg2_reg[j];
        end
    end
endmodule

// File: rtl/vnu_queue.sv
// Short queue between front end and back end.
module vnu_queue #(
    parameter int DW = 99
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [DW-1:0]          push_data,
    input  logic                   pop,
    output logic [DW-1:0]          pop_data,
    output vnu_pkg::queue_status_t qs
);
    logic [DW-1:0]                   mem_reg [vnu_pkg::QUEUE_DEPTH];
    logic [vnu_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [vnu_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [vnu_pkg::QUEUE_CNT_W-1:0] cnt_reg;
    logic [vnu_pkg::QUEUE_CNT_W-1:0] cnt_next;

    assign qs.full  = (cnt_reg == vnu_pkg::QUEUE_CNT_W'(vnu_pkg::QUEUE_DEPTH));
    assign qs.empty = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + vnu_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - vnu_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + vnu_pkg::QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + vnu_pkg::QUEUE_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= vnu_pkg::QUEUE_CNT_W'(vnu_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qs.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qs.empty)
        else $error("pop from empty queue");
endmodule

// File: rtl/vnu_back.sv
// Back end: bit-per-stage search for each unit component, then sign and output register.
module vnu_back #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vnu_pkg::queue_status_t qs,
    input  logic [3*(2*W+1)-1:0]   pop_data,
    output logic                   pop,
    vnu_unit_if.source             unit
);
    localparam int SW = 2 * W;
    localparam int EW = 2 * W + 2 * F + 5;
    localparam int QW = F + 1;
    localparam int UW = F + 2;
    localparam int NS = F + 2;

    logic [NS-1:0]        vld_reg;
    logic signed [EW-1:0] a_reg [NS][3];
    logic signed [EW-1:0] b_reg [NS][3];
    logic signed [EW-1:0] r_reg [NS][3];
    logic signed [EW-1:0] s_reg [NS];
    logic [QW-1:0]        q_reg [NS][3];
    logic [2:0]           neg_reg [NS];
    logic [NS-1:0]        zero_reg;
    logic                 out_vld_reg;
    logic signed [UW-1:0] xo_reg;
    logic signed [UW-1:0] yo_reg;
    logic signed [UW-1:0] zo_reg;
    logic                 zl_reg;
    logic                 en;
    logic signed [EW-1:0] sq0 [3];
    logic signed [EW-1:0] sum0;
    logic signed [UW-1:0] res [3];

    assign en  = !out_vld_reg || unit.ready;
    assign pop = en && !qs.empty;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            sq0[j] = EW'(pop_data[j*(SW+1) +: SW]);
        sum0 = sq0[0] + sq0[1] + sq0[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NS-2:0], pop};
            out_vld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0]    <= sum0;
            zero_reg[0] <= (sum0 == '0);
            for (int j = 0; j < 3; j++)
            begin
                neg_reg[0][j] <= pop_data[j*(SW+1) + SW];
                r_reg[0][j]   <= sq0[j] <<< (2 * F + 2);
                a_reg[0][j]   <= sum0;
                b_reg[0][j]   <= -sum0;
                q_reg[0][j]   <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS - 1; i++)
    begin : g_step
        localparam int K = F - i;
        logic signed [EW-1:0] cand [3];
        logic [2:0]           take;

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                cand[j] = a_reg[i][j] + (b_reg[i][j] <<< (K + 2)) + (s_reg[i] <<< (2 * K + 2));
                take[j] = (cand[j] <= r_reg[i][j]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i+1]    <= s_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    r_reg[i+1][j] <= r_reg[i][j];
                    if (take[j])
                    begin
                        a_reg[i+1][j] <= cand[j];
                        b_reg[i+1][j] <= b_reg[i][j] + (s_reg[i] <<< (K + 1));
                        q_reg[i+1][j] <= q_reg[i][j] | (QW'(1) << K);
                    end
                    else
                    begin
                        a_reg[i+1][j] <= a_reg[i][j];
                        b_reg[i+1][j] <= b_reg[i][j];
                        q_reg[i+1][j] <= q_reg[i][j];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (zero_reg[NS-1])
                res[j] = '0;
            else if (neg_reg[NS-1][j])
                res[j] = -$signed(UW'(q_reg[NS-1][j]));
            else
                res[j] = $signed(UW'(q_reg[NS-1][j]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xo_reg <= res[0];
            yo_reg <= res[1];
            zo_reg <= res[2];
            zl_reg <= zero_reg[NS-1];
        end
    end

    assign unit.valid       = out_vld_reg;
    assign unit.x_unit      = xo_reg;
    assign unit.y_unit      = yo_reg;
    assign unit.z_unit      = zo_reg;
    assign unit.zero_length = zl_reg;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && zl_reg) |-> (xo_reg == '0 && yo_reg == '0 && zo_reg == '0))
        else $error("zero vector with nonzero components");
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (xo_reg <= $signed(UW'(1) <<< F) && xo_reg >= -($signed(UW'(1) <<< F))))
        else $error("unit component out of range");
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[0]) |=> vld_reg[1])
        else $error("pipeline lost a beat");
endmodule
